>>> sv/mbps_pkg.sv
package mbps_pkg;

  // Default window depth; the top level hands it down as MAX_PATTERN_BYTES
  localparam int MaxPatternBytesDef = 16;

  // Fixed by the register layout: two 64-bit pattern words, 16 care bits
  localparam int PatBytes    = 16;
  localparam int PatW        = 8 * PatBytes;
  localparam int LenW        = 5;
  localparam int CountW      = 32;
  localparam int ApbAddrW    = 5;
  localparam int ApbDataW    = 64;

  // Register indexes, byte address = 8 * index
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_CARE_MASK      = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } reg_idx_t;

  // Configuration seen by the scan datapath
  typedef struct packed {
    logic [PatW-1:0]     pattern;        // byte j in bits 8j+7..8j
    logic [PatBytes-1:0] care_mask;
    logic [LenW-1:0]     pattern_length;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic              found;
    logic [CountW-1:0] match_offset;
  } res_t;

endpackage

>>> sv/masked_byte_pattern_scanner_unit.sv
// Channel  Handshake                      Payload
// -------  -----------------------------  ------------------------------
// input    in_valid / in_ready            data_byte, end_of_buffer
// output   out_valid / out_ready          found, match_offset
// config   APB psel/penable/pwrite/pready paddr, pwdata, prdata (64 bit)
//
// One byte per cycle sustained while the result buffer has space. The input
// register loads on the byte's transaction edge, and the compare result is
// then registered into the output register, or into the skid entry while the
// output is held; a full skid entry holds the input register.
// The compare over all window positions is one level of byte comparators
// plus an AND tree; no loop runs over cycles.
// Reset (rst, synchronous) clears the valid flags, the byte count and the
// reported flag; no clearing pass is needed.
// A stalled output fills one skid entry, after which in_ready drops.
module masked_byte_pattern_scanner_unit #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytesDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_buffer,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [31:0]                    match_offset,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbps_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mbps_pkg::ApbDataW-1:0]  pwdata,
  output logic [mbps_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import mbps_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_data;
  logic res_push;
  logic res_space;

  // Configuration registers
  mbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Window, byte count and compare
  mbps_core #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .res_space     (res_space),
    .res_push      (res_push),
    .res           (res)
  );

  // Result register with skid entry
  mbps_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .space     (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign found        = out_data.found;
  assign match_offset = out_data.match_offset;

endmodule

>>> sv/mbps_cfg.sv
module mbps_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbps_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mbps_pkg::ApbDataW-1:0]  pwdata,
  output logic [mbps_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output mbps_pkg::cfg_t                 cfg
);
  import mbps_pkg::*;

  logic [63:0]         pattern_low;
  logic [63:0]         pattern_high;
  logic [PatBytes-1:0] care_mask;
  logic [LenW-1:0]     pattern_length;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[4:3]);

  // Register writes on the APB access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_CARE_MASK:      care_mask      <= pwdata[PatBytes-1:0];
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_CARE_MASK:      prdata = {{(ApbDataW-PatBytes){1'b0}}, care_mask};
      REG_PATTERN_LENGTH: prdata = {{(ApbDataW-LenW){1'b0}}, pattern_length};
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern        = {pattern_high, pattern_low};
  assign cfg.care_mask      = care_mask;
  assign cfg.pattern_length = pattern_length;

endmodule

>>> sv/mbps_core.sv
module mbps_core #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytesDef
) (
  input  logic           clk,
  input  logic           rst,
  input  mbps_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           end_of_buffer,
  input  logic           res_space,
  output logic           res_push,
  output mbps_pkg::res_t res
);
  import mbps_pkg::*;

  localparam int IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // Input register
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              s1_adv;

  // Scan state
  logic [7:0]        window [MAX_PATTERN_BYTES];
  logic [CountW-1:0] count;
  logic              reported;

  logic [7:0]        win_new [MAX_PATTERN_BYTES];
  logic [CountW-1:0] count_next;
  logic [LenW-1:0]   len;
  logic              len_ok;
  logic              pos_ok;
  logic              hit;
  logic [LenW-1:0]   idx;
  logic [7:0]        sel;

  assign s1_adv   = s1_valid & res_space;
  assign in_ready = ~s1_valid | res_space;

  // Input register: one byte per cycle while the result buffer has space
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= end_of_buffer;
    end
  end

  // Window after this byte shifts in; entry 0 is newest
  always_comb begin
    win_new[0] = s1_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_new[k] = window[k-1];
    end
  end

  assign count_next = (count == '1) ? count : count + CountW'(1);
  assign len        = cfg.pattern_length;
  assign len_ok     = (len != '0) && (len <= LenW'(MAX_PATTERN_BYTES));

  // Per-position masked compare; pattern byte j meets window entry len-1-j
  always_comb begin
    pos_ok = 1'b1;
    idx    = '0;
    sel    = '0;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if (LenW'(j) < len) begin
        idx = len - LenW'(j) - LenW'(1);
        sel = (idx < LenW'(MAX_PATTERN_BYTES)) ? win_new[idx[IdxW-1:0]] : 8'h00;
        if (cfg.care_mask[j] && (sel != cfg.pattern[8*j +: 8])) begin
          pos_ok = 1'b0;
        end
      end
    end
  end

  assign hit = len_ok && (count_next >= CountW'(len)) && pos_ok;

  // One result per buffer: first match, or a miss on the last byte
  assign res_push         = s1_adv & ~reported & (hit | s1_last);
  assign res.found        = hit;
  assign res.match_offset = hit ? (count_next - CountW'(len)) : '0;

  // Scan state update; the window needs no clear since only filled entries are compared
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      reported <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last) begin
        count    <= '0;
        reported <= 1'b0;
      end else begin
        count <= count_next;
        if (hit) begin
          reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window[k] <= win_new[k];
      end
    end
  end

  // A miss is only reported at buffer end
  a_miss_on_last: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res.found) |-> s1_last)
    else $error("miss result away from buffer end");

  // Buffer end returns the scan state to idle
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (count == '0) && !reported)
    else $error("scan state not cleared after buffer end");

  // Nothing further is reported once a match of this buffer went out
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.found && !s1_last) |=> !res_push || $past(s1_last) ||
      (count == '0))
    else $error("second result within one buffer");

endmodule

>>> sv/mbps_outbuf.sv
module mbps_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbps_pkg::res_t push_data,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output mbps_pkg::res_t out_data
);
  import mbps_pkg::*;

  logic main_take;
  logic skid_valid;
  res_t skid_data;

  assign space     = ~skid_valid;
  assign main_take = ~out_valid | out_ready;

  // Output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_take) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // Never push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed while buffer full");

  // Skid entry only holds data behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

endmodule

>>> tb/masked_byte_pattern_scanner_unit_tb.sv
module masked_byte_pattern_scanner_unit_tb;
  import mbps_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles  = 8;

  // Scan predictor and expected-result store
  class scan_scoreboard;
    logic [127:0] pattern;
    logic [15:0]  care;
    logic [4:0]   plen;
    logic [7:0]   window [16];
    logic [31:0]  seen;
    bit           reported;
    res_t         expected_q [$];
    int           errors;
    int           byte_cnt;
    int           found_cnt;
    int           miss_cnt;

    function new();
      pattern  = '0;
      care     = '0;
      plen     = '0;
      seen     = '0;
      reported = 0;
      errors   = 0;
      byte_cnt = 0;
      found_cnt = 0;
      miss_cnt = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_LOW:    pattern[63:0]   = v;
        REG_PATTERN_HIGH:   pattern[127:64] = v;
        REG_CARE_MASK:      care            = v[15:0];
        REG_PATTERN_LENGTH: plen            = v[4:0];
        default: ;
      endcase
    endfunction

    // Shift in one accepted byte and queue the result it causes, if any
    function void note_byte(logic [7:0] b, logic last);
      int   i;
      int   j;
      int   len;
      bit   hit;
      res_t r;
      for (i = 15; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (seen != 32'hFFFF_FFFF) seen++;
      byte_cnt++;
      len = plen;
      if (!reported) begin
        hit = (len != 0) && (len <= 16) && (seen >= len);
        for (j = 0; j < 16; j++) begin
          if (hit && j < len && care[j] && window[len-1-j] != pattern[8*j +: 8])
            hit = 0;
        end
        if (hit) begin
          r.found        = 1'b1;
          r.match_offset = seen - len;
          expected_q     = {expected_q, r};
          reported = 1;
          found_cnt++;
        end else if (last) begin
          r.found        = 1'b0;
          r.match_offset = '0;
          expected_q     = {expected_q, r};
          miss_cnt++;
        end
      end
      // buffer boundary clears the scan state
      if (last) begin
        for (i = 0; i < 16; i++) window[i] = '0;
        seen     = '0;
        reported = 0;
      end
    endfunction

    function void check_result(logic f, logic [31:0] off);
      res_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0b match_offset=%0d",
                 $time, f, off);
        errors++;
      end else begin
        r = expected_q.pop_front();
        if (f !== r.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b", $time, r.found, f);
          errors++;
        end
        if (off !== r.match_offset) begin
          $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                   $time, r.match_offset, off);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte     = '0;
  logic                end_of_buffer = 1'b0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                found;
  logic [31:0]         match_offset;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  scan_scoreboard sb = new();

  bit gaps_on;
  bit stall_on;
  int stall_cnt;
  int idle_cycles;
  bit busy;
  int setting_cnt;
  int buffer_cnt;

  masked_byte_pattern_scanner_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_offset  (match_offset),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // Result side back-pressure in short random bursts
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(1, 3);
    end
    out_ready <= (stall_cnt == 0);
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      busy = 0;
      if (in_valid && in_ready) begin
        sb.note_byte(data_byte, end_of_buffer);
        busy = 1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(found, match_offset);
        busy = 1;
      end
      if (psel) busy = 1;
      if (busy) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("masked_byte_pattern_scanner_unit_tb: errors");
        $finish;
      end
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] care, input logic [4:0] len);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {48'b0, care});
    write_reg(REG_PATTERN_LENGTH, {59'b0, len});
    setting_cnt++;
  endtask

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_buffer <= last;
    do @(posedge clk); while (!in_ready);
    if (last) buffer_cnt++;
  endtask

  // Stop sending, wait for all results, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly random, sometimes a pattern byte or an extreme value
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return sb.pattern[8*$urandom_range(0, 15) +: 8];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Buffer of random bytes, optionally carrying the pattern at a random spot
  task automatic send_buffer(input int blen, input bit plant);
    int i;
    int j;
    int pos;
    int len;
    logic [7:0] b;
    len = sb.plen;
    pos = -1;
    if (plant && len >= 1 && len <= 16 && blen >= len)
      pos = $urandom_range(0, blen - len);
    for (i = 0; i < blen; i++) begin
      j = i - pos;
      if (pos >= 0 && j >= 0 && j < len && sb.care[j]) b = sb.pattern[8*j +: 8];
      else b = rand_byte();
      send_byte(b, i == blen - 1);
    end
  endtask

  initial begin
    int phase;
    int phase_items;
    int blen;
    logic [4:0] len;
    logic [15:0] care;
    logic [63:0] lo;
    logic [63:0] hi;

    gaps_on  = 1;
    stall_on = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 4-byte signature, mid-buffer hit then a trailing byte
    set_config(64'h0000_0000_EFBE_ADDE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd4);
    send_byte(8'h11, 0);
    send_byte(8'hDE, 0);
    send_byte(8'hAD, 0);
    send_byte(8'hBE, 0);
    send_byte(8'hEF, 0);
    send_byte(8'h22, 1);
    // hit at offset zero on the final byte
    send_byte(8'hDE, 0);
    send_byte(8'hAD, 0);
    send_byte(8'hBE, 0);
    send_byte(8'hEF, 1);
    // buffer shorter than the pattern
    send_byte(8'hDE, 0);
    send_byte(8'hAD, 1);
    drain();

    // length zero never matches
    set_config(64'h0, 64'h0, 16'h0000, 5'd0);
    send_byte(8'h00, 0);
    send_byte(8'hFF, 1);
    drain();

    // length beyond the window never matches
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    send_byte(8'h00, 0);
    send_byte(8'h00, 0);
    send_byte(8'h00, 1);
    drain();

    // wildcard in the middle of the pattern
    set_config(64'h0000_0000_0003_9901, 64'h0, 16'b101, 5'd3);
    send_byte(8'h01, 0);
    send_byte(8'h7E, 0);
    send_byte(8'h03, 1);
    drain();

    // length change partway through a buffer
    set_config(64'h0000_0000_0000_BBAA, 64'h0, 16'h0003, 5'd2);
    send_byte(8'hAA, 0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_byte(8'h55, 0);
    send_byte(8'hAA, 1);
    drain();

    // Random phases, each with its own setting
    for (phase = 0; phase < 12; phase++) begin
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      care = 16'($urandom);
      case ($urandom_range(0, 7))
        0:       len = 5'd1;
        1:       len = 5'd16;
        2:       len = 5'($urandom_range(17, 31));
        3:       len = 5'd0;
        default: len = 5'($urandom_range(2, 15));
      endcase
      if (phase == 0) begin
        lo = '1; hi = '1; care = 16'hFFFF; len = 5'd16;
      end else if (phase == 1) begin
        lo = '0; hi = '0; care = 16'h0000; len = 5'd16;
      end else if (phase == 2) begin
        care = 16'hFFFF;
      end
      set_config(lo, hi, care, len);

      gaps_on  = (phase < 10) && ($urandom_range(0, 3) != 0);
      stall_on = (phase < 10) && ($urandom_range(0, 3) != 0);

      phase_items = 0;
      while (phase_items < 40) begin
        if ($urandom_range(0, 39) == 0) blen = $urandom_range(64, 128);
        else blen = $urandom_range(1, 20);
        send_buffer(blen, $urandom_range(0, 9) < 7);
        phase_items += blen;
      end
      drain();
    end

    $display("scanned %0d bytes in %0d buffers under %0d register settings",
             sb.byte_cnt, buffer_cnt, setting_cnt);
    $display("results: %0d matches, %0d buffers without a match",
             sb.found_cnt, sb.miss_cnt);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("masked_byte_pattern_scanner_unit_tb: clean");
    end else begin
      $display("masked_byte_pattern_scanner_unit_tb: errors");
    end
    $finish;
  end

endmodule
